// ----- design/ffbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffbt_pkg
// shared types and constants for the first-fit boundary tag allocator
// ----------------------------------------------------------------------------
package ffbt_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int AW           = $clog2(POOL_BYTES);   // header address bits
    localparam int SW           = AW + 1;               // size bits
    localparam int HW           = 2 + 2 * SW;           // header word bits

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_LARGEST = 2'd2;
    localparam logic [1:0] ACT_INIT    = 2'd3;

    typedef struct packed {
        logic          occ;
        logic          last;
        logic [SW-1:0] size;
        logic [SW-1:0] back;
    } hdr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_EVAL,
        ST_SPLIT_WR,
        ST_NXT_RD,
        ST_NXT_WAIT,
        ST_NXT_EVAL,
        ST_PRV_RD,
        ST_PRV_WAIT,
        ST_WB,
        ST_BK_RD,
        ST_BK_WAIT,
        ST_BK_WR,
        ST_DONE
    } state_t;

endpackage

// ----- design/ffbt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffbt_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ffbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- design/first_fit_boundary_tag_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// first-fit allocator over a pool kept as a chain of boundary tag headers
// ----------------------------------------------------------------------------
// channel   dir  handshake              content
// s_axis    in   s_axis_tvalid/tready   action, request_size, block_offset
// m_axis    out  m_axis_tvalid/tready   status, payload_offset, largest_free
// apb       in   psel/penable/pready    pool_size at address 0
//
// one item at a time; every header on a walk passes the read, wait and eval states
// alloc: walk, then optional split write, header write and follower back size;
// largest: walk only; free: walk to its block, then merges, header write and
// back size; init writes header 0, a free below one header skips the walk;
// each ends in the done state. header ram is not cleared by reset; an init transfer must come first.
// s_axis_tready is low from acceptance until the result transfer.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator
    import ffbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // action[1:0], request_size[14:2], block_offset[26:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status[0], payload_offset[12:1], largest_free[25:13]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [SW-1:0] HB = SW'(HEADER_BYTES);
    localparam logic [SW:0]   PB = (SW+1)'(POOL_BYTES);

    state_t state_reg, state_next;
    logic [12:0]   pool_reg;
    logic [1:0]    act_reg;
    logic [SW-1:0] req_reg;
    logic [SW-1:0] tgt_reg;         // free target header (offset - 8)
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic          has_prev_reg, has_prev_next;
    hdr_t          cur_reg, cur_next;      // working copy of header h
    hdr_t          prv_reg, prv_next;
    logic [AW-1:0] bk_reg, bk_next;        // header whose follower gets back
    logic [SW-1:0] bkv_reg, bkv_next;
    logic          status_reg, status_next;
    logic [AW-1:0] pay_reg, pay_next;
    logic [SW-1:0] best_reg, best_next;
    logic          ovalid_reg;

    logic          we;
    logic [AW-1:0] addr;
    hdr_t          wdata, rd;
    logic [HW-1:0] rdata_w;

    ffbt_ram #(.WIDTH(HW), .DEPTH(POOL_BYTES)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata_w)
    );
    assign rd = hdr_t'(rdata_w);

    // shared adder: next header address of cur
    logic [SW:0] nx_sum;
    logic        nx_ok;
    assign nx_sum = {2'b0, h_reg} + (SW+1)'(HB) + {1'b0, cur_reg.size};
    assign nx_ok  = !cur_reg.last && (nx_sum < PB);

    // split arithmetic for alloc
    logic [SW-1:0] rem;
    logic [SW:0]   nh_sum;
    assign rem    = cur_reg.size - req_reg;
    assign nh_sum = {2'b0, h_reg} + (SW+1)'(HB) + {1'b0, req_reg};

    logic [12:0] pclamp;
    assign pclamp = (pool_reg > 13'(POOL_BYTES)) ? 13'(POOL_BYTES) : pool_reg;

    assign pready        = 1'b1;
    assign prdata        = {19'd0, pool_reg};
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, best_reg, pay_reg, status_reg};

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pool_reg   <= 13'd4096;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && !paddr)
            begin
                pool_reg <= pwdata[12:0];
            end
            if (state_reg == ST_DONE)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            act_reg     <= s_axis_tdata[1:0];
            req_reg     <= s_axis_tdata[14:2];
            tgt_reg     <= {1'b0, s_axis_tdata[26:15]} - HB;
        end
        h_reg        <= h_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        cur_reg      <= cur_next;
        prv_reg      <= prv_next;
        bk_reg       <= bk_next;
        bkv_reg      <= bkv_next;
        status_reg   <= status_next;
        pay_reg      <= pay_next;
        best_reg     <= best_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tdata[1:0] == ACT_INIT)
                        state_next = ST_WB;
                    else if (s_axis_tdata[1:0] == ACT_FREE
                             && s_axis_tdata[26:15] < AW'(HEADER_BYTES))
                        state_next = ST_DONE;
                    else
                        state_next = ST_RD;
                end
            end
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT: state_next = ST_EVAL;
            ST_EVAL:
            begin
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (!cur_reg.occ && cur_reg.size >= req_reg)
                        begin
                            if (rem <= HB || nh_sum >= PB)
                                state_next = ST_WB;
                            else
                                state_next = ST_SPLIT_WR;
                        end
                        else if (nx_ok)
                            state_next = ST_RD;
                        else
                            state_next = ST_DONE;
                    end
                    ACT_LARGEST:
                        state_next = nx_ok ? ST_RD : ST_DONE;
                    default:
                    begin
                        if ({1'b0, h_reg} == tgt_reg)
                            state_next = cur_reg.occ ? ST_NXT_RD : ST_DONE;
                        else if (!nx_ok || nx_sum[SW-1:0] > tgt_reg)
                            state_next = ST_DONE;
                        else
                            state_next = ST_RD;
                    end
                endcase
            end
            ST_SPLIT_WR: state_next = ST_WB;
            ST_NXT_RD:   state_next = nx_ok ? ST_NXT_WAIT : ST_PRV_RD;
            ST_NXT_WAIT: state_next = ST_NXT_EVAL;
            ST_NXT_EVAL: state_next = ST_PRV_RD;
            ST_PRV_RD:   state_next = has_prev_reg ? ST_PRV_WAIT : ST_WB;
            ST_PRV_WAIT: state_next = ST_WB;
            ST_WB:       state_next = (act_reg == ACT_INIT) ? ST_DONE : ST_BK_RD;
            ST_BK_RD:    state_next = nx_ok ? ST_BK_WAIT : ST_DONE;
            ST_BK_WAIT:  state_next = ST_BK_WR;
            ST_BK_WR:    state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        h_next        = h_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        cur_next      = cur_reg;
        prv_next      = prv_reg;
        bk_next       = bk_reg;
        bkv_next      = bkv_reg;
        status_next   = status_reg;
        pay_next      = pay_reg;
        best_next     = best_reg;
        we            = 1'b0;
        addr          = h_reg;
        wdata         = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    h_next        = '0;
                    has_prev_next = 1'b0;
                    status_next   = 1'b0;
                    pay_next      = '0;
                    best_next     = '0;
                    cur_next.occ  = 1'b0;
                    cur_next.last = 1'b1;
                    cur_next.back = '0;
                    cur_next.size = (pclamp > 13'(HEADER_BYTES))
                                    ? SW'(pclamp - 13'(HEADER_BYTES)) : '0;
                end
            end
            ST_WAIT: cur_next = rd;
            ST_EVAL:
            begin
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (!cur_reg.occ && cur_reg.size >= req_reg)
                        begin
                            cur_next.occ = 1'b1;
                            pay_next     = h_reg + AW'(HEADER_BYTES);
                            bk_next      = h_reg;
                            bkv_next     = '0;
                            if (!(rem <= HB || nh_sum >= PB))
                            begin
                                prv_next.occ  = 1'b0;
                                prv_next.size = rem - HB;
                                prv_next.back = '0;
                                prv_next.last = cur_reg.last;
                            end
                        end
                        else if (nx_ok)
                            h_next = nx_sum[AW-1:0];
                        else
                            status_next = 1'b1;
                    end
                    ACT_LARGEST:
                    begin
                        if (!cur_reg.occ && cur_reg.size > best_reg)
                            best_next = cur_reg.size;
                        if (nx_ok)
                            h_next = nx_sum[AW-1:0];
                    end
                    default:
                    begin
                        if ({1'b0, h_reg} != tgt_reg && nx_ok
                            && !(nx_sum[SW-1:0] > tgt_reg))
                        begin
                            prev_next     = h_reg;
                            has_prev_next = 1'b1;
                            prv_next      = cur_reg;
                            h_next        = nx_sum[AW-1:0];
                        end
                        else if ({1'b0, h_reg} == tgt_reg)
                            cur_next.occ = 1'b0;
                    end
                endcase
            end
            ST_SPLIT_WR:
            begin
                // write the new free header behind the taken part
                we            = 1'b1;
                addr          = nh_sum[AW-1:0];
                wdata         = prv_reg;
                cur_next.size = req_reg;
                cur_next.last = 1'b0;
                bk_next       = nh_sum[AW-1:0];
                bkv_next      = prv_reg.size;
            end
            ST_NXT_RD:   addr = nx_sum[AW-1:0];
            ST_NXT_WAIT: addr = nx_sum[AW-1:0];
            ST_NXT_EVAL:
            begin
                if (!rd.occ)
                begin
                    cur_next.size = cur_reg.size + rd.size + HB;
                    cur_next.last = rd.last;
                end
            end
            ST_PRV_RD:
            begin
                bk_next  = h_reg;
                bkv_next = cur_reg.size;
            end
            ST_PRV_WAIT:
            begin
                if (!prv_reg.occ)
                begin
                    // back merge keeps the earlier block's own back size
                    h_next        = prev_reg;
                    cur_next      = prv_reg;
                    cur_next.size = prv_reg.size + cur_reg.size + HB;
                    cur_next.last = cur_reg.last;
                    bk_next       = prev_reg;
                    bkv_next      = prv_reg.size + cur_reg.size + HB;
                end
            end
            ST_WB:
            begin
                we    = 1'b1;
                addr  = h_reg;
                wdata = cur_reg;
                if (act_reg != ACT_FREE)
                begin
                    h_next = bk_reg;
                end
                if (act_reg == ACT_ALLOC && bk_reg != h_reg)
                begin
                    cur_next = prv_reg;
                end
            end
            ST_BK_RD:    addr = nx_sum[AW-1:0];
            ST_BK_WAIT:  addr = nx_sum[AW-1:0];
            ST_BK_WR:
            begin
                we         = 1'b1;
                addr       = nx_sum[AW-1:0];
                wdata      = rd;
                wdata.back = bkv_reg;
            end
            default: ;
        endcase
    end

    // free path, writeback of h: the follower must come from the written header
    // (h_reg/cur_reg hold it after ST_WB for a free; for an alloc they move to header bk_reg)

    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("accepted a second item while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> m_axis_tvalid)
        else $error("result not presented after done");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[12:1] == '0))
        else $error("failed alloc with nonzero offset");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT_WR) |-> (nh_sum < PB))
        else $error("split header outside pool");

endmodule

// ----- test/ffbt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffbt_checker
// watches the command, result and register channels of the allocator, keeps
// its own copy of the header chain and compares every result transfer
// ----------------------------------------------------------------------------
module ffbt_checker
    import ffbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        bit          status;
        logic [11:0] payload_offset;
        logic [12:0] largest_free;
    } outcome_t;

    hdr_t        tags [POOL_BYTES];
    int unsigned pool_bytes_cfg;
    outcome_t    expected_q[$];

    assign pending = expected_q.size();

    function automatic bit follow(input int unsigned h, output int unsigned n);
        int unsigned x;
        n = 0;
        if (tags[h].last)
            return 0;
        x = h + HEADER_BYTES + tags[h].size;
        if (x >= POOL_BYTES)
            return 0;
        n = x;
        return 1;
    endfunction

    function automatic void set_follower_back(input int unsigned h, input int unsigned v);
        int unsigned n;
        if (follow(h, n))
            tags[n].back = SW'(v);
    endfunction

    function automatic void format_pool();
        int unsigned p;
        p = (pool_bytes_cfg > POOL_BYTES) ? POOL_BYTES : pool_bytes_cfg;
        tags[0].occ  = 1'b0;
        tags[0].last = 1'b1;
        tags[0].size = (p > HEADER_BYTES) ? SW'(p - HEADER_BYTES) : '0;
        tags[0].back = '0;
    endfunction

    function automatic bit first_fit(input int unsigned req, output int unsigned pay);
        int unsigned h, n, rem, nh;
        bit was_last;
        h = 0;
        pay = 0;
        forever
        begin
            if (!tags[h].occ && tags[h].size >= req)
            begin
                tags[h].occ = 1'b1;
                pay = h + HEADER_BYTES;
                rem = tags[h].size - req;
                nh = h + HEADER_BYTES + req;
                if (rem <= HEADER_BYTES || nh >= POOL_BYTES)
                    set_follower_back(h, 0);
                else
                begin
                    was_last = tags[h].last;
                    tags[h].size = SW'(req);
                    tags[h].last = 1'b0;
                    tags[nh].occ = 1'b0;
                    tags[nh].size = SW'(rem - HEADER_BYTES);
                    tags[nh].back = '0;
                    tags[nh].last = was_last;
                    set_follower_back(nh, tags[nh].size);
                end
                return 1;
            end
            if (!follow(h, n))
                return 0;
            h = n;
        end
    endfunction

    function automatic void release_block(input int unsigned off);
        int unsigned target, h, n, prev;
        bit has_prev;
        h = 0;
        prev = 0;
        has_prev = 0;
        if (off < HEADER_BYTES)
            return;
        target = off - HEADER_BYTES;
        while (h != target)
        begin
            if (!follow(h, n) || n > target)
                return;
            prev = h;
            has_prev = 1;
            h = n;
        end
        if (!tags[h].occ)
            return;
        tags[h].occ = 1'b0;
        if (follow(h, n) && !tags[n].occ)
        begin
            tags[h].size = SW'(tags[h].size + tags[n].size + HEADER_BYTES);
            tags[h].last = tags[n].last;
        end
        // back merge keeps the earlier block's own back size
        if (has_prev && !tags[prev].occ)
        begin
            tags[prev].size = SW'(tags[prev].size + tags[h].size + HEADER_BYTES);
            tags[prev].last = tags[h].last;
            h = prev;
        end
        set_follower_back(h, tags[h].size);
    endfunction

    function automatic int unsigned biggest_hole();
        int unsigned h, n, best;
        h = 0;
        best = 0;
        forever
        begin
            if (!tags[h].occ && tags[h].size > best)
                best = tags[h].size;
            if (!follow(h, n))
                return best;
            h = n;
        end
    endfunction

    function automatic outcome_t predict(input logic [1:0] act, input int unsigned req,
                                         input int unsigned off);
        outcome_t r;
        int unsigned pay;
        r.status = 1'b0;
        r.payload_offset = '0;
        r.largest_free = '0;
        case (act)
            ACT_ALLOC:
            begin
                if (first_fit(req, pay))
                    r.payload_offset = pay[11:0];
                else
                    r.status = 1'b1;
            end
            ACT_FREE:    release_block(off);
            ACT_LARGEST: r.largest_free = 13'(biggest_hole());
            default:     format_pool();
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            pool_bytes_cfg = 4096;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 1'b0)
                pool_bytes_cfg = pwdata[12:0];
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict(s_axis_tdata[1:0], s_axis_tdata[14:2],
                                             s_axis_tdata[26:15]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (m_axis_tdata[0] !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[12:1] !== e.payload_offset)
                    begin
                        $error("payload_offset: expected %0d, got %0d",
                               e.payload_offset, m_axis_tdata[12:1]);
                        fail_count++;
                    end
                    if (m_axis_tdata[25:13] !== e.largest_free)
                    begin
                        $error("largest_free: expected %0d, got %0d",
                               e.largest_free, m_axis_tdata[25:13]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// allocator testbench: directed chain cases, then random alloc/free/query
// traffic (with some inits) over several pool sizes and idle/stall mixes, checked by ffbt_checker
// ----------------------------------------------------------------------------
module tb;
    import ffbt_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // action[1:0], request_size[14:2], block_offset[26:15]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // status[0], payload_offset[12:1], largest_free[25:13]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          cycle_count = 0;
    logic [11:0] live_blocks[$];

    first_fit_boundary_tag_allocator dut (.*);

    ffbt_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver side, with a long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done     <= 1'b1;
            hold_cycles   <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // successful allocations are the only results with a nonzero offset
    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[12:1] != 0)
            live_blocks.push_back(m_axis_tdata[12:1]);

    task automatic send_cmd(input logic [1:0] act, input logic [12:0] req,
                            input logic [11:0] off);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, off, req, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == ACT_INIT)
            live_blocks.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_pool_size(input logic [12:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= {19'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_cmd();
        int          pick;
        int          idx;
        logic [12:0] req;
        pick = $urandom_range(99);
        if (pick < 46)
        begin
            case ($urandom_range(9))
                0:       req = 13'($urandom_range(4096));
                1:       req = 13'($urandom());
                2:       req = 13'($urandom_range(16));
                default: req = 13'($urandom_range(300));
            endcase
            send_cmd(ACT_ALLOC, req, 12'($urandom()));
        end
        else if (pick < 84)
        begin
            if (live_blocks.size() != 0 && $urandom_range(9) < 8)
            begin
                idx = $urandom_range(live_blocks.size() - 1);
                send_cmd(ACT_FREE, 13'($urandom()), live_blocks[idx]);
                live_blocks.delete(idx);
            end
            else
                send_cmd(ACT_FREE, 13'($urandom()), 12'($urandom()));
        end
        else if (pick < 97)
            send_cmd(ACT_LARGEST, 13'($urandom()), 12'($urandom()));
        else
            send_cmd(ACT_INIT, 13'($urandom()), 12'($urandom()));
    endtask

    initial
    begin
        logic [12:0] pool_list[8];
        int          ph;
        pool_list = '{13'd4096, 13'd16, 13'd5, 13'd8191, 13'd1000, 13'd300, 13'd2500, 13'd4096};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 1'b0;
        pwdata         = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full pool, exact fit, misfit, coalescing both ways, bad frees
        send_cmd(ACT_INIT, 0, 0);
        send_cmd(ACT_LARGEST, 0, 0);
        send_cmd(ACT_ALLOC, 13'd4096, 0);
        send_cmd(ACT_ALLOC, 13'd4088, 0);
        send_cmd(ACT_LARGEST, 0, 0);
        send_cmd(ACT_ALLOC, 0, 0);
        send_cmd(ACT_FREE, 0, 12'd8);
        send_cmd(ACT_FREE, 0, 12'd8);
        send_cmd(ACT_FREE, 0, 12'd0);
        send_cmd(ACT_FREE, 0, 12'd3);
        send_cmd(ACT_FREE, 0, 12'd4095);
        send_cmd(ACT_ALLOC, 0, 0);
        send_cmd(ACT_ALLOC, 13'd100, 0);
        send_cmd(ACT_ALLOC, 13'd200, 0);
        send_cmd(ACT_ALLOC, 13'd4080, 0);
        send_cmd(ACT_FREE, 0, 12'd8);
        send_cmd(ACT_FREE, 0, 12'd224);
        send_cmd(ACT_FREE, 0, 12'd116);
        send_cmd(ACT_LARGEST, 0, 0);
        send_cmd(ACT_ALLOC, 13'd4079, 0);
        send_cmd(ACT_FREE, 0, 12'd50);
        send_cmd(ACT_ALLOC, 13'd8191, 0);
        send_cmd(ACT_ALLOC, 13'd4072, 0);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            write_pool_size(pool_list[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            send_cmd(ACT_INIT, 0, 0);
            if (ph == 4)
                hold_go <= 1'b1;
            repeat (165) random_cmd();
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ffbt_pkg.sv
design/ffbt_ram.sv
design/first_fit_boundary_tag_allocator.sv
test/ffbt_checker.sv
test/tb.sv
